### design/adip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package adip_pkg;

  localparam int ICON_PIXELS = 32;

  localparam int COORD_W   = 5;
  localparam int COV_W     = 8;
  localparam int CH_W      = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RED   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = CFG_IDX_W'(2);

  localparam logic [CH_W-1:0] RESET_RED   = CH_W'(229);
  localparam logic [CH_W-1:0] RESET_GREEN = CH_W'(57);
  localparam logic [CH_W-1:0] RESET_BLUE  = CH_W'(53);

  localparam int COORD_MAX  = (1 << COORD_W) - 1;
  localparam int DELTA_HI   = 2 * COORD_MAX + 1 - ICON_PIXELS;
  localparam int DELTA_MAX  = (ICON_PIXELS - 1 > DELTA_HI) ? ICON_PIXELS - 1 : DELTA_HI;
  localparam int DELTA_W    = $clog2(DELTA_MAX + 1);
  localparam int SQ_MAX     = 2 * DELTA_MAX * DELTA_MAX;
  localparam int SQ_W       = $clog2(SQ_MAX + 1);
  localparam int FRAC_SH    = 14;
  localparam int RAD_W      = (SQ_W + FRAC_SH + 1) / 2;
  localparam int STEPS_PER_STAGE = 4;
  localparam int SQRT_STAGES = (RAD_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int ROOT_W     = STEPS_PER_STAGE * SQRT_STAGES;
  localparam int V_W        = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;

  localparam int HALF       = ICON_PIXELS * 128;
  localparam int TH_W       = $clog2(HALF + 1);
  localparam int CMP_W      = (ROOT_W > TH_W) ? ROOT_W : TH_W;
  localparam logic [CMP_W-1:0] TH_A = CMP_W'(HALF - 512);
  localparam logic [CMP_W-1:0] TH_B = CMP_W'(HALF - 256);
  localparam logic [CMP_W-1:0] TH_C = CMP_W'(HALF);

  localparam int Q8_W = 9;
  localparam logic [Q8_W-1:0] Q8_ONE = Q8_W'(256);
  localparam int SHADOW_Q8 = 102;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } adip_rgb_t;

  typedef struct packed {
    logic             valid;
    logic [V_W-1:0]   rad;
    logic [REM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [COV_W-1:0] cov;
  } adip_sqrt_t;

  typedef struct packed {
    logic             valid;
    logic [COV_W-1:0] cov;
    logic [CH_W-1:0]  alpha;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } adip_pix_t;

endpackage
`default_nettype wire

### design/adip_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface adip_in_if import adip_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [COV_W-1:0]   glyph_coverage;

  modport source (output valid, pixel_x, pixel_y, glyph_coverage, input ready);
  modport sink (input valid, pixel_x, pixel_y, glyph_coverage, output ready);
endinterface

interface adip_out_if import adip_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] alpha_out;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;

  modport source (output valid, alpha_out, red_out, green_out, blue_out, input ready);
  modport sink (input valid, alpha_out, red_out, green_out, blue_out, output ready);
endinterface

interface adip_cfg_if import adip_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CH_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/antialiased_disc_icon_pixel_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake     payload
// in_chan   in   valid/ready   pixel_x[4:0] pixel_y[4:0] glyph_coverage[7:0]
// out_chan  out  valid/ready   alpha_out red_out green_out blue_out [7:0] each
// cfg_chan  in   valid/ready   index[1:0] data[7:0], ready always high
//
// one item per clock when unstalled; pipeline: input, sqrt, shade, blend
// the square root runs four result bits per stage, which sets the depth
// rst_n is synchronous: clears the valid bits and loads the default colour
// a stalled output freezes the whole pipeline, so nothing is dropped
module antialiased_disc_icon_pixel_top import adip_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  adip_in_if.sink    in_chan,
  adip_out_if.source out_chan,
  adip_cfg_if.sink   cfg_chan
);

  adip_rgb_t  fill_r;
  adip_sqrt_t s1_r, s1_nxt;
  adip_sqrt_t sq_chain [SQRT_STAGES+1];
  adip_pix_t  shade_pix;
  adip_pix_t  out_pix;
  logic       adv;

  assign adv            = out_chan.ready || !out_pix.valid;
  assign in_chan.ready  = adv;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r.red   <= RESET_RED;
      fill_r.green <= RESET_GREEN;
      fill_r.blue  <= RESET_BLUE;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_RED:   fill_r.red   <= cfg_chan.data;
        CFG_GREEN: fill_r.green <= cfg_chan.data;
        CFG_BLUE:  fill_r.blue  <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // squared distance of the pixel centre, in half pixels
  always_comb begin
    int xi;
    int yi;
    logic [DELTA_W-1:0] adx;
    logic [DELTA_W-1:0] ady;
    logic [SQ_W-1:0]    sq;
    xi  = int'({in_chan.pixel_x, 1'b1});
    yi  = int'({in_chan.pixel_y, 1'b1});
    adx = DELTA_W'((xi >= ICON_PIXELS) ? xi - ICON_PIXELS : ICON_PIXELS - xi);
    ady = DELTA_W'((yi >= ICON_PIXELS) ? yi - ICON_PIXELS : ICON_PIXELS - yi);
    sq  = SQ_W'(SQ_W'(adx) * SQ_W'(adx)) + SQ_W'(SQ_W'(ady) * SQ_W'(ady));
    s1_nxt.valid = in_chan.valid;
    s1_nxt.rad   = V_W'({sq, FRAC_SH'(0)});
    s1_nxt.rem   = '0;
    s1_nxt.root  = '0;
    s1_nxt.cov   = in_chan.glyph_coverage;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  assign sq_chain[0] = s1_r;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    adip_sqrt_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .stage_i (sq_chain[g]),
      .stage_o (sq_chain[g+1])
    );
  end

  adip_shade u_shade (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .dist_i (sq_chain[SQRT_STAGES]),
    .fill_i (fill_r),
    .pix_o  (shade_pix)
  );

  adip_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .pix_i (shade_pix),
    .pix_o (out_pix)
  );

  assign out_chan.valid     = out_pix.valid;
  assign out_chan.alpha_out = out_pix.alpha;
  assign out_chan.red_out   = out_pix.red;
  assign out_chan.green_out = out_pix.green;
  assign out_chan.blue_out  = out_pix.blue;

endmodule
`default_nettype wire

### design/adip_sqrt_step.sv
`timescale 1ns / 1ps
`default_nettype none
module adip_sqrt_step import adip_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire adip_sqrt_t stage_i,
  output adip_sqrt_t      stage_o
);

  adip_sqrt_t stage_r;
  adip_sqrt_t stage_nxt;

  // restoring square root, two radicand bits per step
  always_comb begin
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    stage_nxt = stage_i;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      rem_sh = {stage_nxt.rem[REM_W-3:0], stage_nxt.rad[V_W-1 -: 2]};
      trial  = {stage_nxt.root, 2'b01};
      stage_nxt.rad = {stage_nxt.rad[V_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        stage_nxt.rem  = rem_sh - trial;
        stage_nxt.root = {stage_nxt.root[ROOT_W-2:0], 1'b1};
      end else begin
        stage_nxt.rem  = rem_sh;
        stage_nxt.root = {stage_nxt.root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule
`default_nettype wire

### design/adip_shade.sv
`timescale 1ns / 1ps
`default_nettype none
module adip_shade import adip_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire adip_sqrt_t dist_i,
  input  wire adip_rgb_t  fill_i,
  output adip_pix_t       pix_o
);

  typedef struct packed {
    logic             valid;
    logic [COV_W-1:0] cov;
    logic [Q8_W-1:0]  main_cov;
    logic [Q8_W-1:0]  inv;
    logic [14:0]      ring_s;
  } cov_st_t;

  typedef struct packed {
    logic             valid;
    logic [COV_W-1:0] cov;
    logic [Q8_W-1:0]  main_cov;
    logic [Q8_W-1:0]  inv;
    logic [7:0]       shadow;
    adip_rgb_t        rgb;
  } shd_st_t;

  typedef struct packed {
    logic             valid;
    logic [COV_W-1:0] cov;
    logic [9:0]       a;
    adip_rgb_t        rgb;
  } acc_st_t;

  cov_st_t c1_r, c1_nxt;
  shd_st_t c2_r, c2_nxt;
  acc_st_t c3_r, c3_nxt;
  adip_pix_t c4_r, c4_nxt;

  // disc and ring coverage from the distance
  always_comb begin
    logic [CMP_W-1:0] d;
    logic [Q8_W-1:0]  ring;
    d = CMP_W'(dist_i.root);
    c1_nxt.valid = dist_i.valid;
    c1_nxt.cov   = dist_i.cov;
    if (d <= TH_A) begin
      c1_nxt.main_cov = Q8_ONE;
    end else if (d < TH_B) begin
      c1_nxt.main_cov = Q8_W'(TH_B - d);
    end else begin
      c1_nxt.main_cov = '0;
    end
    if (d > TH_A && d <= TH_C) begin
      ring = (d <= TH_B) ? Q8_ONE : Q8_W'(TH_C - d);
    end else begin
      ring = '0;
    end
    c1_nxt.inv    = Q8_ONE - c1_nxt.main_cov;
    c1_nxt.ring_s = 15'(ring) * 15'(SHADOW_Q8);
  end

  function automatic logic [CH_W-1:0] scale_ch(input logic [CH_W-1:0] c,
                                               input logic [Q8_W-1:0] m);
    logic [16:0] p;
    logic [8:0]  s;
    p = 17'(c) * 17'(m);
    s = p[16:8];
    return (s > 9'd255) ? 8'd255 : s[7:0];
  endfunction

  always_comb begin
    logic [23:0] p;
    p = 24'(c1_r.ring_s) * 24'(c1_r.inv);
    c2_nxt.valid     = c1_r.valid;
    c2_nxt.cov       = c1_r.cov;
    c2_nxt.main_cov  = c1_r.main_cov;
    c2_nxt.inv       = c1_r.inv;
    c2_nxt.shadow    = p[23:16];
    c2_nxt.rgb.red   = scale_ch(fill_i.red, c1_r.main_cov);
    c2_nxt.rgb.green = scale_ch(fill_i.green, c1_r.main_cov);
    c2_nxt.rgb.blue  = scale_ch(fill_i.blue, c1_r.main_cov);
  end

  always_comb begin
    logic [16:0] p;
    p = 17'(c2_r.shadow) * 17'(c2_r.inv);
    c3_nxt.valid = c2_r.valid;
    c3_nxt.cov   = c2_r.cov;
    c3_nxt.rgb   = c2_r.rgb;
    c3_nxt.a     = 10'(c2_r.main_cov) + 10'(p[16:8]);
  end

  // alpha times 255 over 256
  always_comb begin
    logic [17:0] p;
    logic [9:0]  s;
    p = {c3_r.a, 8'b0} - 18'(c3_r.a);
    s = p[17:8];
    c4_nxt.valid = c3_r.valid;
    c4_nxt.cov   = c3_r.cov;
    c4_nxt.alpha = (s > 10'd255) ? 8'd255 : s[7:0];
    c4_nxt.red   = c3_r.rgb.red;
    c4_nxt.green = c3_r.rgb.green;
    c4_nxt.blue  = c3_r.rgb.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid <= 1'b0;
      c2_r.valid <= 1'b0;
      c3_r.valid <= 1'b0;
      c4_r.valid <= 1'b0;
    end else if (adv) begin
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
      c3_r <= c3_nxt;
      c4_r <= c4_nxt;
    end
  end

  assign pix_o = c4_r;

endmodule
`default_nettype wire

### design/adip_blend.sv
`timescale 1ns / 1ps
`default_nettype none
module adip_blend import adip_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire adip_pix_t pix_i,
  output adip_pix_t      pix_o
);

  typedef struct packed {
    logic             valid;
    logic [COV_W-1:0] cov;
    logic [15:0]      pa;
    logic [15:0]      pr;
    logic [15:0]      pg;
    logic [15:0]      pb;
  } prod_st_t;

  prod_st_t  b1_r, b1_nxt;
  adip_pix_t b2_r, b2_nxt;

  // white over the pixel: t + v*(255-t)/255
  always_comb begin
    logic [15:0] tc;
    tc = 16'(8'd255 - pix_i.cov);
    b1_nxt.valid = pix_i.valid;
    b1_nxt.cov   = pix_i.cov;
    b1_nxt.pa    = 16'(pix_i.alpha) * tc;
    b1_nxt.pr    = 16'(pix_i.red) * tc;
    b1_nxt.pg    = 16'(pix_i.green) * tc;
    b1_nxt.pb    = 16'(pix_i.blue) * tc;
  end

  function automatic logic [CH_W-1:0] over(input logic [COV_W-1:0] t,
                                           input logic [15:0] x);
    logic [16:0] q;
    logic [9:0]  s;
    // divide by 255 through the reciprocal with a rounding correction
    q = 17'(x) + 17'(x[15:8]) + 17'd1;
    s = 10'(t) + 10'(q[16:8]);
    return (s > 10'd255) ? 8'd255 : s[7:0];
  endfunction

  always_comb begin
    b2_nxt.valid = b1_r.valid;
    b2_nxt.cov   = b1_r.cov;
    b2_nxt.alpha = over(b1_r.cov, b1_r.pa);
    b2_nxt.red   = over(b1_r.cov, b1_r.pr);
    b2_nxt.green = over(b1_r.cov, b1_r.pg);
    b2_nxt.blue  = over(b1_r.cov, b1_r.pb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r.valid <= 1'b0;
      b2_r.valid <= 1'b0;
    end else if (adv) begin
      b1_r <= b1_nxt;
      b2_r <= b2_nxt;
    end
  end

  assign pix_o = b2_r;

endmodule
`default_nettype wire

### tb/sv/antialiased_disc_icon_pixel_top_tb.sv
`timescale 1ns / 1ps
module antialiased_disc_icon_pixel_top_tb;
  import adip_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COV_W-1:0]   cov;
  } pixel_item_t;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } argb_t;

  logic clk;
  logic rst_n;

  adip_in_if  in_chan ();
  adip_out_if out_chan ();
  adip_cfg_if cfg_chan ();

  antialiased_disc_icon_pixel_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  pixel_item_t pending_pixels[$];
  argb_t       expected_pixels[$];
  adip_rgb_t   fill_colour;
  int          error_count;
  int          in_gap;
  int          out_gap;
  int          stall_cycles;
  bit          idle_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [CH_W-1:0] clip_byte(input int v);
    return (v > 255) ? CH_W'(255) : CH_W'(v);
  endfunction

  function automatic logic [CH_W-1:0] blend_white(input int t, input int v);
    return clip_byte(t + (v * (255 - t)) / 255);
  endfunction

  function automatic argb_t predict_pixel(input pixel_item_t item);
    int dx;
    int dy;
    int unsigned radicand;
    int unsigned root;
    int unsigned trial;
    int d;
    int half;
    int disc_cov;
    int ring;
    int shadow;
    int a;
    int t;
    argb_t p;
    dx = 2 * int'(item.x) + 1 - ICON_PIXELS;
    dy = 2 * int'(item.y) + 1 - ICON_PIXELS;
    radicand = (dx * dx + dy * dy) * 16384;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= radicand) begin
        root = trial;
      end
    end
    d = root;
    half = ICON_PIXELS * 128;
    disc_cov = 0;
    if (d <= half - 512) begin
      disc_cov = 256;
    end else if (d < half - 256) begin
      disc_cov = half - 256 - d;
    end
    shadow = 0;
    if (d > half - 512 && d <= half) begin
      ring = (d > half - 256) ? half - d : 256;
      shadow = (ring * SHADOW_Q8 * (256 - disc_cov)) >> 16;
    end
    a = disc_cov + ((shadow * (256 - disc_cov)) >> 8);
    p.alpha = clip_byte((a * 255) >> 8);
    p.red = clip_byte((int'(fill_colour.red) * disc_cov) >> 8);
    p.green = clip_byte((int'(fill_colour.green) * disc_cov) >> 8);
    p.blue = clip_byte((int'(fill_colour.blue) * disc_cov) >> 8);
    t = item.cov;
    if (t != 0) begin
      p.alpha = blend_white(t, p.alpha);
      p.red = blend_white(t, p.red);
      p.green = blend_white(t, p.green);
      p.blue = blend_white(t, p.blue);
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_pixels.push_back(predict_pixel(
          '{x: in_chan.pixel_x, y: in_chan.pixel_y, cov: in_chan.glyph_coverage}));
      end
      if (!(in_chan.valid && !in_chan.ready)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_chan.valid <= 1'b0;
        end else if (pending_pixels.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(0, 2);
          in_chan.valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          pixel_item_t nxt;
          nxt = pending_pixels.pop_front();
          in_chan.pixel_x <= nxt.x;
          in_chan.pixel_y <= nxt.y;
          in_chan.glyph_coverage <= nxt.cov;
          in_chan.valid <= 1'b1;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected item alpha", out_chan.alpha_out, -1);
        end else begin
          argb_t want;
          want = expected_pixels.pop_front();
          if (out_chan.alpha_out !== want.alpha)
            report_mismatch("alpha_out", out_chan.alpha_out, want.alpha);
          if (out_chan.red_out !== want.red)
            report_mismatch("red_out", out_chan.red_out, want.red);
          if (out_chan.green_out !== want.green)
            report_mismatch("green_out", out_chan.green_out, want.green);
          if (out_chan.blue_out !== want.blue)
            report_mismatch("blue_out", out_chan.blue_out, want.blue);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        out_gap <= $urandom_range(0, 2);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("antialiased_disc_icon_pixel_top test failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] val);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    case (idx)
      CFG_RED: fill_colour.red = val;
      CFG_GREEN: fill_colour.green = val;
      CFG_BLUE: fill_colour.blue = val;
      default: ;
    endcase
  endtask

  task automatic set_colour(input int r, input int g, input int b);
    write_reg(CFG_RED, CH_W'(r));
    write_reg(CFG_GREEN, CH_W'(g));
    write_reg(CFG_BLUE, CH_W'(b));
  endtask

  task automatic queue_pixel(input int x, input int y, input int cov);
    pending_pixels.push_back('{x: COORD_W'(x), y: COORD_W'(y), cov: COV_W'(cov)});
  endtask

  task automatic queue_random(input int n);
    repeat (n) begin
      queue_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, 1) ? 0 : $urandom_range(0, 255));
    end
  endtask

  task automatic drain;
    while (pending_pixels.size() != 0 || in_chan.valid || expected_pixels.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    idle_on = 1'b1;
    error_count = 0;
    in_gap = 0;
    out_gap = 0;
    stall_cycles = 0;
    in_chan.valid = 1'b0;
    in_chan.pixel_x = '0;
    in_chan.pixel_y = '0;
    in_chan.glyph_coverage = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_RED;
    cfg_chan.data = '0;
    fill_colour = '{red: RESET_RED, green: RESET_GREEN, blue: RESET_BLUE};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corners, centre, both ramps, coverage extremes
    queue_pixel(0, 0, 0);
    queue_pixel(31, 31, 0);
    queue_pixel(0, 31, 255);
    queue_pixel(31, 0, 255);
    queue_pixel(15, 15, 0);
    queue_pixel(16, 16, 1);
    queue_pixel(15, 16, 128);
    queue_pixel(1, 15, 0);
    queue_pixel(0, 15, 0);
    queue_pixel(15, 0, 0);
    queue_pixel(15, 1, 254);
    queue_pixel(30, 16, 0);
    queue_pixel(31, 16, 0);
    queue_pixel(2, 15, 0);
    queue_pixel(5, 5, 0);
    queue_pixel(4, 4, 0);
    queue_pixel(26, 26, 0);
    queue_pixel(27, 27, 0);
    queue_pixel(5, 5, 200);
    queue_pixel(0, 15, 77);
    queue_pixel(16, 31, 0);
    queue_pixel(31, 31, 255);
    queue_random(300);
    drain();

    set_colour(0, 255, 128);
    write_reg(CFG_SPARE, CH_W'(77));
    queue_random(400);
    drain();

    set_colour(255, 255, 255);
    queue_random(400);
    drain();

    set_colour(0, 0, 0);
    queue_random(300);
    drain();

    set_colour($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    write_reg(CFG_SPARE, CH_W'($urandom_range(0, 255)));
    queue_random(400);
    while (pending_pixels.size() != 0) @(posedge clk);
    idle_on <= 1'b0;
    queue_random(200);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("antialiased_disc_icon_pixel_top test passed");
    end else begin
      $display("antialiased_disc_icon_pixel_top test failed");
    end
    $finish;
  end

endmodule
